[sv/b2da_pkg.sv]
package b2da_pkg;

  localparam int VALUE_FIELD_BITS   = 32;
  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int CHAR_BITS          = 8;
  // binary bits folded into the BCD word per pipeline stage (the last stage takes the rest)
  localparam int DABBLE_STEPS       = 8;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;

  // bits of the value that reach the converter
  function automatic int eff_bits(input int value_bits);
    return (value_bits < VALUE_FIELD_BITS) ? value_bits : VALUE_FIELD_BITS;
  endfunction

  // decimal digits needed for the largest value of the given width
  function automatic int dec_digits(input int bits);
    longint unsigned m;
    int n;
    m = (64'd1 << bits) - 64'd1;
    n = 0;
    do begin
      n++;
      m = m / 10;
    end while (m != 0);
    return n;
  endfunction

endpackage

[sv/b2da_pipe.sv]
module b2da_pipe #(
  parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_func,
  input  logic [b2da_pkg::VALUE_FIELD_BITS-1:0] in_value,
  output logic out_valid,
  input  logic out_ready,
  output logic out_neg,
  output logic [4*b2da_pkg::dec_digits(b2da_pkg::eff_bits(VALUE_BITS))-1:0] out_bcd,
  output logic [$clog2(b2da_pkg::dec_digits(b2da_pkg::eff_bits(VALUE_BITS)))-1:0] out_cnt
);
  import b2da_pkg::*;

  localparam int MAG_BITS = eff_bits(VALUE_BITS);
  localparam int DIGITS   = dec_digits(MAG_BITS);
  localparam int BCD_W    = 4 * DIGITS;
  localparam int CNT_W    = $clog2(DIGITS);
  localparam int NS       = (MAG_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS;
  localparam int NSTG     = NS + 2;
  localparam int W        = BCD_W + MAG_BITS;
  localparam logic HAS_SIGN = (VALUE_BITS <= VALUE_FIELD_BITS);

  // one shift-add-3 iteration over {bcd, binary}
  function automatic logic [W-1:0] dabble1(input logic [W-1:0] x);
    logic [W-1:0] y;
    logic [3:0] d;
    int k;
    y = x;
    for (k = 0; k < DIGITS; k++) begin
      d = y[MAG_BITS + 4*k +: 4];
      if (d >= 4'd5) begin
        y[MAG_BITS + 4*k +: 4] = d + 4'd3;
      end
    end
    return y << 1;
  endfunction

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  logic            neg_q [NS+1];
  logic [BCD_W-1:0]    bcd_q [NS+1];
  logic [MAG_BITS-1:0] bin_q [NS+1];

  logic [MAG_BITS-1:0] v_in;
  logic [MAG_BITS-1:0] mag_in;
  logic                neg_in;

  assign rdy[NSTG] = out_ready;
  assign in_ready  = rdy[0];

  genvar gi;
  generate
    for (gi = 0; gi < NSTG; gi++) begin : g_rdy
      assign rdy[gi] = !vld[gi] || rdy[gi+1];
    end
  endgenerate

  // stage 0: sign handling and magnitude
  assign v_in   = in_value[MAG_BITS-1:0];
  assign neg_in = in_func && HAS_SIGN && v_in[MAG_BITS-1];
  assign mag_in = neg_in ? (~v_in + MAG_BITS'(1)) : v_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      neg_q[0] <= neg_in;
      bcd_q[0] <= '0;
      bin_q[0] <= mag_in;
    end
  end

  // stages 1..NS: double dabble, DABBLE_STEPS bits per stage, the last stage takes the rest
  generate
    for (gi = 1; gi <= NS; gi++) begin : g_dabble
      localparam int ITERS = (gi < NS) ? DABBLE_STEPS : MAG_BITS - DABBLE_STEPS * (NS - 1);
      logic [W-1:0] x;

      always_comb begin
        x = {bcd_q[gi-1], bin_q[gi-1]};
        for (int j = 0; j < ITERS; j++) begin
          x = dabble1(x);
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[gi] <= 1'b0;
        end else if (rdy[gi]) begin
          vld[gi] <= vld[gi-1];
        end
        if (rdy[gi] && vld[gi-1]) begin
          neg_q[gi] <= neg_q[gi-1];
          bcd_q[gi] <= x[W-1 -: BCD_W];
          bin_q[gi] <= x[MAG_BITS-1:0];
        end
      end
    end
  endgenerate

  // last stage: find the leading digit and move it to the top
  logic [CNT_W-1:0] top_idx;
  logic [CNT_W-1:0] lz;
  logic [BCD_W-1:0] aligned;

  always_comb begin
    top_idx = '0;
    for (int k = 1; k < DIGITS; k++) begin
      if (bcd_q[NS][4*k +: 4] != 4'd0) begin
        top_idx = CNT_W'(k);
      end
    end
    lz      = CNT_W'(DIGITS - 1) - top_idx;
    aligned = bcd_q[NS] << {lz, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NSTG-1] <= 1'b0;
    end else if (rdy[NSTG-1]) begin
      vld[NSTG-1] <= vld[NSTG-2];
    end
    if (rdy[NSTG-1] && vld[NSTG-2]) begin
      out_neg <= neg_q[NS];
      out_bcd <= aligned;
      out_cnt <= top_idx;
    end
  end

  assign out_valid = vld[NSTG-1];

  a_lead_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_cnt != '0 |-> out_bcd[BCD_W-1 -: 4] != 4'd0)
    else $error("leading digit is zero on a multi-digit number");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_bcd[BCD_W-1 -: 4] <= 4'd9)
    else $error("leading BCD digit out of range");

  a_neg_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_neg |-> out_bcd != '0)
    else $error("minus sign on a zero magnitude");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !rdy[1] |=> vld[0] && $stable(bin_q[0]))
    else $error("stage 0 lost its word under stall");

endmodule

[sv/binary_to_decimal_ascii_unit.sv]
// Binary to decimal ASCII converter.
//
// The slave channel takes one word per number: s_tdata holds the 32-bit value,
// s_tuser selects unsigned (0) or signed two's complement (1). Only the low
// VALUE_BITS bits of the value are converted.
// The master channel gives the decimal text one character per word, most
// significant digit first: a '-' for a negative signed value, then the digits
// with no leading zeros ('0' for zero). m_tlast marks the final character.
// Conversion is a double-dabble pipeline folding 8 bits per stage, plus one
// sign stage and one alignment stage; a number's first character is loaded
// into the serializer register once its word has passed all of these stages.
// A number gives as many output characters as it has, 1 to 11; the character
// serializer sets the sustained rate, and the pipeline behind it keeps taking
// words until it fills.
// When the receiver stalls, the current character holds and the pipeline
// backs up stage by stage until s_tready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and the serializer.
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [b2da_pkg::VALUE_FIELD_BITS-1:0] s_tdata, // [31:0] value
  input  logic s_tuser,                                  // [0] func
  output logic m_tvalid,
  input  logic m_tready,
  output logic [b2da_pkg::CHAR_BITS-1:0] m_tdata,        // [7:0] character
  output logic m_tlast
);
  import b2da_pkg::*;

  localparam int MAG_BITS = eff_bits(VALUE_BITS);
  localparam int DIGITS   = dec_digits(MAG_BITS);
  localparam int BCD_W    = 4 * DIGITS;
  localparam int CNT_W    = $clog2(DIGITS);

  logic             p_valid;
  logic             p_ready;
  logic             p_neg;
  logic [BCD_W-1:0] p_bcd;
  logic [CNT_W-1:0] p_cnt;

  b2da_pipe #(
    .VALUE_BITS(VALUE_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser),
    .in_value (s_tdata),
    .out_valid(p_valid),
    .out_ready(p_ready),
    .out_neg  (p_neg),
    .out_bcd  (p_bcd),
    .out_cnt  (p_cnt)
  );

  // serializer: the current digit always sits in the top nibble
  logic             active;
  logic             neg;
  logic [BCD_W-1:0] sh;
  logic [CNT_W-1:0] cnt;
  logic             fire;
  logic             done;
  logic             load;

  assign fire    = m_tvalid && m_tready;
  assign done    = fire && !neg && cnt == '0;
  assign p_ready = !active || done;
  assign load    = p_valid && p_ready;

  assign m_tvalid = active;
  assign m_tdata  = neg ? CHAR_MINUS : CHAR_ZERO + {4'd0, sh[BCD_W-1 -: 4]};
  assign m_tlast  = !neg && cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (done) begin
      active <= 1'b0;
    end
    if (load) begin
      neg <= p_neg;
      sh  <= p_bcd;
      cnt <= p_cnt;
    end else if (fire) begin
      if (neg) begin
        neg <= 1'b0;
      end else begin
        // advance to the next digit
        sh  <= sh << 4;
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata != CHAR_MINUS)
    else $error("text ends on a minus sign");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (rst)
    fire && neg |=> m_tvalid && !neg)
    else $error("minus sign not followed by a digit");

  a_no_load_mid_text: assert property (@(posedge clk) disable iff (rst)
    active && !done |-> !load)
    else $error("new number loaded before text finished");

endmodule

[tb/tb_binary_to_decimal_ascii_unit.sv]
module tb_binary_to_decimal_ascii_unit;
  import b2da_pkg::*;

  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 last;
  } text_char_t;

  class decimal_text_board;
    text_char_t pending_chars[$];
    int         errors = 0;

    // spell the number the way the converter should and queue its characters
    function void note_number(bit func, logic [VALUE_FIELD_BITS-1:0] value);
      logic [VALUE_FIELD_BITS-1:0] magnitude;
      logic [3:0]                  digits[$];
      text_char_t                  c;
      magnitude = value;
      if (func && value[VALUE_FIELD_BITS-1]) begin
        c.character = CHAR_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
        // wraps to 2^31 for the most negative pattern
        magnitude = -value;
      end
      do begin
        digits.push_front(4'(magnitude % 10));
        magnitude = magnitude / 10;
      end while (magnitude != 0);
      foreach (digits[i]) begin
        c.character = CHAR_ZERO + CHAR_BITS'(digits[i]);
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_BITS-1:0] character, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $error("character: expected none, actual %0d", character);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (character !== want.character) begin
        $error("character: expected %0d, actual %0d", want.character, character);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [VALUE_FIELD_BITS-1:0] s_tdata = '0;   // [31:0] value
  logic                        s_tuser = 1'b0; // [0] func
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [CHAR_BITS-1:0]        m_tdata;        // [7:0] character
  logic                        m_tlast;

  decimal_text_board board = new();
  int send_gap_pct  = 0;
  int recv_stall_pct = 0;

  binary_to_decimal_ascii_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_number(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_char(m_tdata, m_tlast);
  end

  // receiver: random stall bursts while stall odds are nonzero
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic send_number(bit func, logic [VALUE_FIELD_BITS-1:0] value);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the sender off until every queued character has come out
  task automatic drain_text();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_FIELD_BITS-1:0] pick_value();
    logic [VALUE_FIELD_BITS-1:0] pow10;
    pow10 = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 999);
      6: begin
        repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
        return pow10 + $urandom_range(0, 2) - 1;
      end
      7: begin
        if ($urandom_range(0, 1)) return 32'h8000_0000 + $urandom_range(0, 3);
        return 32'hFFFF_FFFF - $urandom_range(0, 5);
      end
      8:       return -$urandom_range(1, 1000);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  // bit 32 is func, the rest is the value
  logic [VALUE_FIELD_BITS:0] directed_words[] = '{
    {1'b0, 32'd0},          {1'b1, 32'd0},          {1'b0, 32'd1},
    {1'b1, 32'd1},          {1'b0, 32'd9},          {1'b0, 32'd10},
    {1'b0, 32'd99},         {1'b0, 32'd100},        {1'b1, 32'hFFFF_FFFF},
    {1'b0, 32'hFFFF_FFFF},  {1'b1, 32'h8000_0000},  {1'b0, 32'h8000_0000},
    {1'b1, 32'h7FFF_FFFF},  {1'b0, 32'h7FFF_FFFF},  {1'b1, 32'h8000_0001},
    {1'b0, 32'd999999999},  {1'b0, 32'd1000000000}, {1'b1, 32'd999999999},
    {1'b1, 32'hFFFF_FFF6},  {1'b1, 32'hFFFF_FFF7},  {1'b0, 32'd4294967290},
    {1'b0, 32'h5555_5555},  {1'b1, 32'hAAAA_AAAA},  {1'b0, 32'd1234567890}
  };

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    recv_stall_pct = 20;
    send_gap_pct   = 20;
    foreach (directed_words[i])
      send_number(directed_words[i][VALUE_FIELD_BITS], directed_words[i][VALUE_FIELD_BITS-1:0]);
    drain_text();

    for (int n = 0; n < 330; n++) begin
      if (n % 50 == 0) begin
        send_gap_pct   = pick_odds();
        recv_stall_pct = pick_odds();
      end
      if (n == 170) drain_text();
      send_number($urandom_range(0, 1), pick_value());
    end

    // closing stretch at full rate on both sides
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 56; n++) send_number($urandom_range(0, 1), pick_value());

    drain_text();
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
